### rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GLU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define GLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/glu_pkg.sv
package glu_pkg;

   // fixed field widths of the transactions
   localparam int DIVISOR_WIDTH  = 16;
   localparam int MULTIPLE_WIDTH = 32;
   localparam int FIELD_WIDTH    = 16;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture operands
      logic gcd_step;    // one binary gcd iteration
      logic div_start;   // latch gcd, set up division
      logic div_step;    // one restoring division bit
      logic mul_step;    // quotient times second operand
      logic out_load;    // move result into output register
   } glu_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic zero_operand;
      logic gcd_equal;
      logic out_free;
   } glu_status_type;

endpackage

### rtl/gcd_lcm_unit_core.sv
// channel  | direction | ports                          | contents
// req      | in        | req_tvalid req_tready req_tdata | operand pair
// rsp      | out       | rsp_tvalid rsp_tready rsp_tdata | gcd, lcm
//          |           | rsp_tuser                       | operand error flag
//
// one operand pair at a time (W = operand width in use, at most 16): the
// binary gcd loop needs up to 2*W iterations, the restoring divider W,
// then one multiply and one load
// a zero operand skips the arithmetic and goes straight to the output load
// the next pair is taken while a result still waits in the output register
// reset is synchronous and active high; no memory, nothing to clear
`include "assert_macros.svh"

module gcd_lcm_unit_core #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] first_operand, [31:16] second_operand
   // response transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] common_divisor, [47:16] common_multiple
   output logic        rsp_tuser    // [0] operand_error
);

   // only the low operand bits take part; the input fields are 16 bits wide
   localparam int DataWidth = (OPERAND_WIDTH < glu_pkg::FIELD_WIDTH) ?
                              OPERAND_WIDTH : glu_pkg::FIELD_WIDTH;

   glu_pkg::glu_cmd_type    cmd;
   glu_pkg::glu_status_type status;

   logic [glu_pkg::DIVISOR_WIDTH-1:0]  common_divisor;
   logic [glu_pkg::MULTIPLE_WIDTH-1:0] common_multiple;
   logic                               operand_error;

   // sequencing: load, gcd loop, divide, multiply, result hand-over
   glu_ctrl #(
      .DATA_WIDTH (DataWidth)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // operand registers, gcd and divide units, multiplier, output register
   glu_datapath #(
      .DATA_WIDTH (DataWidth)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .first_operand   (req_tdata[15:0]),
      .second_operand  (req_tdata[31:16]),
      .common_divisor  (common_divisor),
      .common_multiple (common_multiple),
      .operand_error   (operand_error),
      .out_valid       (rsp_tvalid),
      .out_taken       (rsp_tready)
   );

   assign rsp_tdata = {common_multiple, common_divisor};
   assign rsp_tuser = operand_error;

   // an error result carries zero in both fields
   `GLU_ASSERT_IMPLY(a_error_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   // a good result never has a zero divisor or multiple
   `GLU_ASSERT_IMPLY(a_good_nonzero, clock, reset, rsp_tvalid && !rsp_tuser,
                     (rsp_tdata[15:0] != '0) && (rsp_tdata[47:16] != '0))
   // one pair at a time: ready drops after a transaction is taken
   `GLU_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

### rtl/glu_datapath.sv
module glu_datapath #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  glu_pkg::glu_cmd_type                cmd,
   output glu_pkg::glu_status_type             status,
   input  logic [glu_pkg::FIELD_WIDTH-1:0]     first_operand,
   input  logic [glu_pkg::FIELD_WIDTH-1:0]     second_operand,
   output logic [glu_pkg::DIVISOR_WIDTH-1:0]   common_divisor,
   output logic [glu_pkg::MULTIPLE_WIDTH-1:0]  common_multiple,
   output logic                                operand_error,
   output logic                                out_valid,
   input  logic                                out_taken
);

   localparam int ShiftWidth = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
   localparam int ProdWidth  = 2 * DATA_WIDTH;

   logic [DATA_WIDTH-1:0] orig_a_ff, orig_a_in;
   logic [DATA_WIDTH-1:0] orig_b_ff, orig_b_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DATA_WIDTH-1:0] y_ff, y_in;
   logic [ShiftWidth-1:0] k_ff, k_in;
   logic [DATA_WIDTH-1:0] gcd_ff, gcd_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [ProdWidth-1:0]  lcm_ff, lcm_in;
   logic                  err_ff, err_in;
   logic [glu_pkg::DIVISOR_WIDTH-1:0]  div_out_ff, div_out_in;
   logic [glu_pkg::MULTIPLE_WIDTH-1:0] mul_out_ff, mul_out_in;
   logic                  err_out_ff, err_out_in;
   logic                  valid_ff, valid_in;

   logic [DATA_WIDTH:0]   rem_shift;
   logic [DATA_WIDTH:0]   rem_diff;

   assign rem_shift = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, gcd_ff};

   always_comb begin
      orig_a_in  = orig_a_ff;
      orig_b_in  = orig_b_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      k_in       = k_ff;
      gcd_in     = gcd_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      lcm_in     = lcm_ff;
      err_in     = err_ff;
      div_out_in = div_out_ff;
      mul_out_in = mul_out_ff;
      err_out_in = err_out_ff;
      valid_in   = valid_ff & ~out_taken;

      if (cmd.load) begin
         orig_a_in = first_operand[DATA_WIDTH-1:0];
         orig_b_in = second_operand[DATA_WIDTH-1:0];
         x_in      = first_operand[DATA_WIDTH-1:0];
         y_in      = second_operand[DATA_WIDTH-1:0];
         k_in      = '0;
         err_in    = (first_operand[DATA_WIDTH-1:0] == '0) ||
                     (second_operand[DATA_WIDTH-1:0] == '0);
      end

      // binary gcd, one reduction per cycle
      if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_in = (x_ff - y_ff) >> 1;
         end else begin
            y_in = (y_ff - x_ff) >> 1;
         end
      end

      if (cmd.div_start) begin
         gcd_in = x_ff << k_ff;
         rem_in = '0;
         quo_in = orig_a_ff;
      end

      // restoring division of first operand by gcd
      if (cmd.div_step) begin
         if (!rem_diff[DATA_WIDTH]) begin
            rem_in = rem_diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end

      if (cmd.mul_step) begin
         lcm_in = ProdWidth'(quo_ff) * ProdWidth'(orig_b_ff);
      end

      if (cmd.out_load) begin
         div_out_in = err_ff ? '0 : glu_pkg::DIVISOR_WIDTH'(gcd_ff);
         mul_out_in = err_ff ? '0 : glu_pkg::MULTIPLE_WIDTH'(lcm_ff);
         err_out_in = err_ff;
         valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      orig_a_ff  <= orig_a_in;
      orig_b_ff  <= orig_b_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      gcd_ff     <= gcd_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      lcm_ff     <= lcm_in;
      err_ff     <= err_in;
      div_out_ff <= div_out_in;
      mul_out_ff <= mul_out_in;
      err_out_ff <= err_out_in;
   end

   assign status.zero_operand = err_ff;
   assign status.gcd_equal    = (x_ff == y_ff);
   assign status.out_free     = ~valid_ff | out_taken;

   assign common_divisor  = div_out_ff;
   assign common_multiple = mul_out_ff;
   assign operand_error   = err_out_ff;
   assign out_valid       = valid_ff;

endmodule

### rtl/glu_ctrl.sv
module glu_ctrl #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  glu_pkg::glu_status_type status,
   output glu_pkg::glu_cmd_type    cmd
);

   localparam int CountWidth = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

   typedef enum logic [2:0] {
      IDLE,
      GCD,
      DIV,
      MUL,
      FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic                  ready_ff, ready_in;
   logic [CountWidth-1:0] count_ff, count_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (in_valid && ready_ff) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               state_in = GCD;
            end
         end
         GCD: begin
            if (status.zero_operand) begin
               state_in = FINISH;
            end else if (status.gcd_equal) begin
               cmd.div_start = 1'b1;
               count_in      = '0;
               state_in      = DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == CountWidth'(DATA_WIDTH - 1)) begin
               state_in = MUL;
            end
         end
         MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = FINISH;
         end
         FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               ready_in     = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            ready_in = 1'b1;
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         count_ff <= count_in;
      end
   end

   assign in_ready = ready_ff;

endmodule

### tb/tb_top.sv
module tb_top;

   // field widths taken from the package
   localparam int DIVISOR_WIDTH  = glu_pkg::DIVISOR_WIDTH;
   localparam int MULTIPLE_WIDTH = glu_pkg::MULTIPLE_WIDTH;
   localparam int FIELD_WIDTH    = glu_pkg::FIELD_WIDTH;

   // expected result of one operand pair, field widths as on the response bus
   typedef struct packed {
      logic [DIVISOR_WIDTH-1:0]  divisor;
      logic [MULTIPLE_WIDTH-1:0] multiple;
      logic                      zero_operand;
   } pair_result_type;

   // one row of the directed stimulus; typed rows carry a hand-written result
   typedef struct packed {
      logic [FIELD_WIDTH-1:0] first;
      logic [FIELD_WIDTH-1:0] second;
      logic                   typed;
      pair_result_type        result;
   } stim_row_type;

   // note queued by the driver per request, consumed when the request is taken
   typedef struct packed {
      logic            typed;
      pair_result_type result;
   } request_note_type;

   // receiver behaviour, chosen anew at random each time the current mode runs out
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_PATTERN
   } ready_mode_type;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1880;
   // tail wait sized for a worst pair: gcd loop, divider bits, multiply and load
   localparam int TAIL_CYCLES  = 64;
   localparam int RUN_LIMIT    = 40_000_000;
   localparam int N_DIRECTED   = 23;

   // directed rows: zero operands, extremes, equal operands, then a spread of
   // pairs left to the predictor
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{16'd0,     16'd0,     1'b1, '{16'd0,     32'd0,          1'b1}},
      '{16'd0,     16'd1,     1'b1, '{16'd0,     32'd0,          1'b1}},
      '{16'd1,     16'd0,     1'b1, '{16'd0,     32'd0,          1'b1}},
      '{16'd0,     16'd65535, 1'b1, '{16'd0,     32'd0,          1'b1}},
      '{16'd65535, 16'd0,     1'b1, '{16'd0,     32'd0,          1'b1}},
      '{16'd1,     16'd1,     1'b1, '{16'd1,     32'd1,          1'b0}},
      '{16'd65535, 16'd65535, 1'b1, '{16'd65535, 32'd65535,      1'b0}},
      '{16'd1,     16'd65535, 1'b1, '{16'd1,     32'd65535,      1'b0}},
      '{16'd65535, 16'd1,     1'b1, '{16'd1,     32'd65535,      1'b0}},
      '{16'd65535, 16'd65534, 1'b1, '{16'd1,     32'd4294770690, 1'b0}},
      '{16'd12345, 16'd12345, 1'b1, '{16'd12345, 32'd12345,      1'b0}},
      '{16'd32768, 16'd32768, 1'b1, '{16'd32768, 32'd32768,      1'b0}},
      '{16'd17,    16'd17,    1'b1, '{16'd17,    32'd17,         1'b0}},
      '{16'hAAAA,  16'h5555,  1'b0, '0},
      '{16'd32768, 16'd16384, 1'b0, '0},
      '{16'd12,    16'd18,    1'b0, '0},
      '{16'd65521, 16'd65519, 1'b0, '0},
      '{16'd2,     16'd3,     1'b0, '0},
      '{16'd1024,  16'd768,   1'b0, '0},
      '{16'd65534, 16'd32767, 1'b0, '0},
      '{16'h8000,  16'd1,     1'b0, '0},
      '{16'h7FFF,  16'hFFFE,  1'b0, '0},
      '{16'd48,    16'd180,   1'b0, '0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [15:0] first_operand, [31:16] second_operand
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [15:0] common_divisor, [47:16] common_multiple
   logic        rsp_tuser;        // [0] operand_error

   request_note_type request_notes [$];
   pair_result_type  pending_results [$];

   int          mismatches     = 0;
   int          results_seen   = 0;
   int          pairs_sent     = 0;
   int          zero_pairs     = 0;
   int          equal_pairs    = 0;
   int          factor_pairs   = 0;

   ready_mode_type ready_mode  = READY_ALWAYS;
   int          mode_left      = 0;
   logic [7:0]  ready_pattern  = 8'hFF;

   gcd_lcm_unit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(RUN_LIMIT);
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // gcd by euclid, lcm as (first / gcd) * second; a zero operand flags an error
   function automatic pair_result_type gcd_lcm_of(input logic [FIELD_WIDTH-1:0] first,
                                                   input logic [FIELD_WIDTH-1:0] second);
      pair_result_type        res;
      logic [FIELD_WIDTH-1:0] x;
      logic [FIELD_WIDTH-1:0] y;
      logic [FIELD_WIDTH-1:0] r;
      res = '0;
      if (first == '0 || second == '0) begin
         res.zero_operand = 1'b1;
      end else begin
         x = first;
         y = second;
         while (y != '0) begin
            r = x % y;
            x = y;
            y = r;
         end
         res.divisor  = x;
         res.multiple = MULTIPLE_WIDTH'(first / x) * MULTIPLE_WIDTH'(second);
      end
      return res;
   endfunction

   // compare one response transaction against the oldest pending result
   task automatic check_response();
      pair_result_type want;
      pair_result_type got;
      got.divisor      = rsp_tdata[15:0];
      got.multiple     = rsp_tdata[47:16];
      got.zero_operand = rsp_tuser;
      results_seen++;
      if (pending_results.size() == 0) begin
         $display("%0t unexpected response: expected none, actual gcd %0d lcm %0d err %0b",
                  $time, got.divisor, got.multiple, got.zero_operand);
         mismatches++;
      end else begin
         want = pending_results.pop_front();
         if (got.divisor !== want.divisor) begin
            $display("%0t common_divisor: expected %0d, actual %0d",
                     $time, want.divisor, got.divisor);
            mismatches++;
         end
         if (got.multiple !== want.multiple) begin
            $display("%0t common_multiple: expected %0d, actual %0d",
                     $time, want.multiple, got.multiple);
            mismatches++;
         end
         if (got.zero_operand !== want.zero_operand) begin
            $display("%0t operand_error: expected %0b, actual %0b",
                     $time, want.zero_operand, got.zero_operand);
            mismatches++;
         end
      end
   endtask

   // both channels watched at the edge; values read here are the pre-edge ones
   always @(posedge clock) begin : watch_channels
      request_note_type note;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_response();
         if (req_tvalid && req_tready) begin
            note = request_notes.pop_front();
            if (note.typed)
               pending_results.push_back(note.result);
            else
               pending_results.push_back(gcd_lcm_of(req_tdata[15:0], req_tdata[31:16]));
         end
      end
   end

   // receiver back-pressure: always ready, mostly ready, rarely ready, or a
   // rotating 8-bit pattern, each held for a random stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode    = ready_mode_type'($urandom_range(0, 3));
            mode_left     = $urandom_range(50, 600);
            ready_pattern = 8'($urandom_range(1, 255));
         end
         mode_left--;
         case (ready_mode)
            READY_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            READY_MOSTLY: begin
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
            READY_RARELY: begin
               rsp_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_tready    <= ready_pattern[7];
               ready_pattern  = {ready_pattern[6:0], ready_pattern[7]};
            end
         endcase
      end
   end

   // offer one pair and hold it until the handshake completes
   task automatic send_pair(input logic [FIELD_WIDTH-1:0] first,
                            input logic [FIELD_WIDTH-1:0] second,
                            input logic typed, input pair_result_type typed_result);
      request_note_type note;
      note.typed  = typed;
      note.result = typed_result;
      request_notes.push_back(note);
      if (first == '0 || second == '0)
         zero_pairs++;
      else if (first == second)
         equal_pairs++;
      pairs_sent++;
      req_tdata  <= {second, first};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // sender gap; valid only dropped when there is a gap at all
   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // random pair, weighted towards the interesting classes
   task automatic pick_pair(output logic [FIELD_WIDTH-1:0] first,
                            output logic [FIELD_WIDTH-1:0] second);
      int kind;
      int factor;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         // zero operand on one side or both
         first  = FIELD_WIDTH'($urandom_range(0, 65535));
         second = FIELD_WIDTH'($urandom_range(0, 65535));
         case ($urandom_range(0, 2))
            0: first = '0;
            1: second = '0;
            default: begin
               first  = '0;
               second = '0;
            end
         endcase
      end else if (kind < 16) begin
         first  = FIELD_WIDTH'($urandom_range(1, 65535));
         second = first;
      end else if (kind < 46) begin
         // shared factor, so the gcd is at least two
         factor = $urandom_range(2, 2048);
         first  = FIELD_WIDTH'(factor * $urandom_range(1, 65535 / factor));
         second = FIELD_WIDTH'(factor * $urandom_range(1, 65535 / factor));
         factor_pairs++;
      end else if (kind < 60) begin
         first  = FIELD_WIDTH'($urandom_range(1, 255));
         second = FIELD_WIDTH'($urandom_range(1, 255));
      end else if (kind < 70) begin
         // odd part times a power of two, stresses the binary gcd shifts
         first  = FIELD_WIDTH'(($urandom_range(1, 255) | 1) << $urandom_range(0, 8));
         second = FIELD_WIDTH'(($urandom_range(1, 255) | 1) << $urandom_range(0, 8));
      end else begin
         first  = FIELD_WIDTH'($urandom);
         second = FIELD_WIDTH'($urandom);
      end
   endtask

   initial begin : stimulus
      logic [FIELD_WIDTH-1:0] first;
      logic [FIELD_WIDTH-1:0] second;
      int                     burst_left;
      int                     gap;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows back to back
      foreach (directed_rows[i])
         send_pair(directed_rows[i].first, directed_rows[i].second,
                   directed_rows[i].typed, directed_rows[i].result);
      wait_for_drain();

      // random pairs in bursts; gaps up to a full transaction so that a new
      // pair can land on any phase of the one in flight
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            wait_for_drain();
         end else if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
               0, 1, 2: gap = 0;
               3:       gap = $urandom_range(20, 70);
               default: gap = $urandom_range(1, 12);
            endcase
            idle_sender(gap);
         end
         burst_left--;
         pick_pair(first, second);
         send_pair(first, second, 1'b0, '0);
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) begin
         $display("%0t %0d results never arrived", $time, pending_results.size());
         mismatches++;
      end
      $display("run: %0d operand pairs, %0d with a zero operand, %0d equal, %0d with a factor",
               pairs_sent, zero_pairs, equal_pairs, factor_pairs);
      $display("run: %0d responses checked, %0d field mismatches", results_seen, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
